// ===== design/sksf_pkg.sv =====
// ----------------------------------------------------------------------------
// sksf_pkg
// Shared types and constants for the spline knot segment finder: the command
// codes, the input and result words, and the per-parameter metadata word.
// ----------------------------------------------------------------------------
package sksf_pkg;

    localparam int PARAM_W = 6;   // parameter index field
    localparam int KIDX_W  = 4;   // knot index field
    localparam int KCNT_W  = 5;   // knot count field
    localparam int SEG_W   = 4;   // segment index field
    localparam int VALUE_W = 32;  // signed Q16.16 value

    localparam logic [1:0] CMD_WRITE_KNOT = 2'd0;
    localparam logic [1:0] CMD_SET_COUNT  = 2'd1;
    localparam logic [1:0] CMD_FIND       = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic [PARAM_W-1:0]        param_index;
        logic [KIDX_W-1:0]         knot_index;
        logic [KCNT_W-1:0]         knot_count;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [PARAM_W-1:0] param_index_out;
        logic [SEG_W-1:0]   segment;
        logic               empty_res;
    } t_out_word;

    // Knot count and last-segment hint kept for each parameter.
    typedef struct packed {
        logic [KCNT_W-1:0] count;
        logic [SEG_W-1:0]  hint;
    } t_meta_word;

    typedef struct packed {
        logic               en;
        logic [PARAM_W-1:0] addr;
        t_meta_word         word;
    } t_meta_wr;

endpackage

// ===== design/sksf_meta_store.sv =====
// ----------------------------------------------------------------------------
// sksf_meta_store
// Per-parameter knot count and hint memory with registered read.
// Entries not written since reset read as zero through a valid bit per entry.
// ----------------------------------------------------------------------------
module sksf_meta_store #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [sksf_pkg::PARAM_W-1:0] i_rd_addr,
    input  sksf_pkg::t_meta_wr          i_wr,
    output sksf_pkg::t_meta_word        o_rd_word
);
    import sksf_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_meta_word r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_meta_word r_rd_word;
    logic       r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr[IW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[IW-1:0]] <= i_wr.word;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr[IW-1:0]];
            r_rd_hit  <= r_valid[i_rd_addr[IW-1:0]];
        end
    end

    assign o_rd_word = r_rd_hit ? r_rd_word : '0;

endmodule

// ===== design/spline_knot_segment_finder_core.sv =====
// ----------------------------------------------------------------------------
// spline_knot_segment_finder_core
// Finds the knot segment that holds a query value for one of many spline
// parameters, using a clamp check, a last-segment hint and a binary search.
//
//  Channel | Signals                    | Direction | Word
//  --------+----------------------------+-----------+------------------------
//  input   | i_valid, o_ready, i_data   | in        | t_in_word (command)
//  result  | o_valid, i_ready, o_data   | out       | t_out_word (find only)
//
// Knot writes and count writes leave the block idle and may follow back to
// back. A find reads the count and hint of the parameter and ends there for
// a parameter with no knots; otherwise it reads the knot memory as needed
// for the first knot, the last knot, the two hinted knots and up to four
// search probes at sixteen knots, then loads the result register.
// Reset clears the count and hint of every parameter at once (valid bits);
// knot positions are undefined until written. A stalled result holds the
// block in its final state, and a write takes no input word meanwhile.
// ----------------------------------------------------------------------------
module spline_knot_segment_finder_core #(
    parameter int MAX_PARAMS = 64,
    parameter int MAX_KNOTS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sksf_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sksf_pkg::t_out_word o_data
);
    import sksf_pkg::*;

    // Only 64 parameters can be addressed by the index field.
    localparam int EFF_PARAMS = (MAX_PARAMS > 64) ? 64 : MAX_PARAMS;
    localparam int KDEPTH     = EFF_PARAMS * MAX_KNOTS;
    localparam int KAW        = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_LO,
        S_HI,
        S_H1,
        S_H0,
        S_SRCH,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Latched query and search state.
    logic [PARAM_W-1:0]        r_param, n_param;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [KCNT_W-1:0]         r_count, n_count;
    logic [SEG_W-1:0]          r_hint, n_hint;
    logic [SEG_W-1:0]          r_lo, n_lo;
    logic [SEG_W-1:0]          r_hi, n_hi;
    logic [SEG_W-1:0]          r_mid, n_mid;
    logic [SEG_W-1:0]          r_seg, n_seg;
    logic                      r_empty, n_empty;
    logic                      r_out_valid, n_out_valid;
    t_out_word                 r_out, n_out;

    // Knot memory.
    logic signed [VALUE_W-1:0] r_knot_mem [KDEPTH];
    logic signed [VALUE_W-1:0] r_knot_rd;
    logic                      knot_wr_en;
    logic [KAW-1:0]            knot_wr_addr;
    logic                      knot_rd_en;
    logic [SEG_W-1:0]          knot_rd_idx;
    logic [KAW-1:0]            knot_rd_addr;

    // Metadata store.
    t_meta_wr   meta_wr;
    t_meta_word meta_rd;

    logic accept;
    logic in_range;
    logic [KCNT_W-1:0] sat_count;
    logic [SEG_W-1:0]  srch_lo, srch_hi;

    // Clamp a segment to count minus two when the count exceeds one.
    function automatic logic [SEG_W-1:0] f_clamp(input logic [SEG_W-1:0] seg,
                                                 input logic [KCNT_W-1:0] n);
        logic [SEG_W-1:0] res;
        res = seg;
        if (n > KCNT_W'(1) && {1'b0, seg} >= n - KCNT_W'(1)) begin
            res = SEG_W'(n - KCNT_W'(2));
        end
        return res;
    endfunction

    function automatic logic [SEG_W-1:0] f_mid(input logic [SEG_W-1:0] lo,
                                               input logic [SEG_W-1:0] hi);
        logic [SEG_W:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[SEG_W:1];
    endfunction

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign in_range = int'(i_data.param_index) < MAX_PARAMS;
    assign sat_count = (int'(i_data.knot_count) > MAX_KNOTS) ?
                       KCNT_W'(MAX_KNOTS) : i_data.knot_count;

    assign knot_wr_en   = accept && in_range && (i_data.command == CMD_WRITE_KNOT)
                          && (int'(i_data.knot_index) < MAX_KNOTS);
    assign knot_wr_addr = KAW'(int'(i_data.param_index) * MAX_KNOTS
                               + int'(i_data.knot_index));
    assign knot_rd_addr = KAW'(int'(r_param) * MAX_KNOTS + int'(knot_rd_idx));

    always_ff @(posedge i_clk) begin
        if (knot_wr_en) begin
            r_knot_mem[knot_wr_addr] <= i_data.value;
        end
        if (knot_rd_en) begin
            r_knot_rd <= r_knot_mem[knot_rd_addr];
        end
    end

    sksf_meta_store #(
        .DEPTH (EFF_PARAMS)
    ) u_meta (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_data.param_index),
        .i_wr      (meta_wr),
        .o_rd_word (meta_rd)
    );

    // Bounds of a fresh binary search over the whole table.
    assign srch_lo = '0;
    assign srch_hi = SEG_W'(r_count - KCNT_W'(1));

    always_comb begin
        logic [SEG_W-1:0] nl;
        logic [SEG_W-1:0] nh;
        logic             start_search;

        n_state     = r_state;
        n_param     = r_param;
        n_value     = r_value;
        n_count     = r_count;
        n_hint      = r_hint;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_seg       = r_seg;
        n_empty     = r_empty;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        knot_rd_en  = 1'b0;
        knot_rd_idx = '0;
        meta_wr     = '0;
        nl          = r_lo;
        nh          = r_hi;
        start_search = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept && in_range) begin
                    n_param = i_data.param_index;
                    n_value = i_data.value;
                    case (i_data.command)
                        CMD_SET_COUNT: begin
                            meta_wr.en         = 1'b1;
                            meta_wr.addr       = i_data.param_index;
                            meta_wr.word.count = sat_count;
                            meta_wr.word.hint  = '0;
                        end
                        CMD_FIND: begin
                            n_state = S_META;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_META: begin
                n_count = meta_rd.count;
                n_hint  = meta_rd.hint;
                if (meta_rd.count == '0) begin
                    // No knots: report the stored hint and leave it alone.
                    n_seg   = meta_rd.hint;
                    n_empty = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_empty     = 1'b0;
                    knot_rd_en  = 1'b1;
                    knot_rd_idx = '0;
                    n_state     = S_LO;
                end
            end
            S_LO: begin
                if (r_value <= r_knot_rd) begin
                    n_seg   = f_clamp('0, r_count);
                    n_state = S_DONE;
                end else begin
                    knot_rd_en  = 1'b1;
                    knot_rd_idx = SEG_W'(r_count - KCNT_W'(1));
                    n_state     = S_HI;
                end
            end
            S_HI: begin
                if (r_value >= r_knot_rd) begin
                    n_seg   = f_clamp(SEG_W'(r_count - KCNT_W'(1)), r_count);
                    n_state = S_DONE;
                end else if ({1'b0, r_hint} + KCNT_W'(1) < r_count) begin
                    knot_rd_en  = 1'b1;
                    knot_rd_idx = r_hint + SEG_W'(1);
                    n_state     = S_H1;
                end else begin
                    start_search = 1'b1;
                end
            end
            S_H1: begin
                if (r_knot_rd > r_value) begin
                    knot_rd_en  = 1'b1;
                    knot_rd_idx = r_hint;
                    n_state     = S_H0;
                end else begin
                    start_search = 1'b1;
                end
            end
            S_H0: begin
                if (r_value >= r_knot_rd) begin
                    n_seg   = f_clamp(r_hint, r_count);
                    n_state = S_DONE;
                end else begin
                    start_search = 1'b1;
                end
            end
            S_SRCH: begin
                if (r_value > r_knot_rd) begin
                    nl = r_mid;
                end else begin
                    nh = r_mid;
                end
                n_lo = nl;
                n_hi = nh;
                if (nh - nl > SEG_W'(1)) begin
                    n_mid       = f_mid(nl, nh);
                    knot_rd_en  = 1'b1;
                    knot_rd_idx = f_mid(nl, nh);
                end else begin
                    n_seg   = f_clamp(nl, r_count);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid           = 1'b1;
                    n_out.param_index_out = r_param;
                    n_out.segment         = r_seg;
                    n_out.empty_res       = r_empty;
                    if (!r_empty) begin
                        meta_wr.en         = 1'b1;
                        meta_wr.addr       = r_param;
                        meta_wr.word.count = r_count;
                        meta_wr.word.hint  = r_seg;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The hint did not cover the value: search the whole table.
        if (start_search) begin
            n_lo = srch_lo;
            n_hi = srch_hi;
            if (srch_hi - srch_lo > SEG_W'(1)) begin
                n_mid       = f_mid(srch_lo, srch_hi);
                knot_rd_en  = 1'b1;
                knot_rd_idx = f_mid(srch_lo, srch_hi);
                n_state     = S_SRCH;
            end else begin
                n_seg   = f_clamp(srch_lo, r_count);
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_param <= n_param;
        r_value <= n_value;
        r_count <= n_count;
        r_hint  <= n_hint;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_seg   <= n_seg;
        r_empty <= n_empty;
        r_out   <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
